FILE: rtl/hpq_pkg.sv
// ----------------------------------------------------------------------------
// hpq_pkg
// Types, operation codes and status codes shared by the heap priority queue.
// ----------------------------------------------------------------------------
package hpq_pkg;

   localparam int KEY_W  = 32;
   localparam int FUNC_W = 2;
   localparam int STAT_W = 2;
   localparam int CNT_W  = 9;

   // operation codes
   localparam logic [FUNC_W-1:0] FUNC_INSERT  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_EXTRACT = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd2;

   // status codes
   localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [FUNC_W-1:0]       func;
      logic signed [KEY_W-1:0] new_key;
   } req_type;

   typedef struct packed {
      logic signed [KEY_W-1:0] max_key;
      logic [STAT_W-1:0]       status;
      logic [CNT_W-1:0]        entry_count;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UP,
      ST_EX0,
      ST_DN,
      ST_DONE
   } state_type;

endpackage

FILE: rtl/hpq_key_ram.sv
// ----------------------------------------------------------------------------
// hpq_key_ram
// Key storage: one write port, two read ports, read data registered.
// ----------------------------------------------------------------------------
module hpq_key_ram #(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = 8
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [ADDR_W-1:0]                 wr_addr,
   input  logic signed [hpq_pkg::KEY_W-1:0]  wr_data,
   input  logic [ADDR_W-1:0]                 rd_addr_a,
   input  logic [ADDR_W-1:0]                 rd_addr_b,
   output logic signed [hpq_pkg::KEY_W-1:0]  rd_data_a,
   output logic signed [hpq_pkg::KEY_W-1:0]  rd_data_b
);

   logic signed [hpq_pkg::KEY_W-1:0] key_mem [DEPTH];
   logic signed [hpq_pkg::KEY_W-1:0] rd_data_a_ff;
   logic signed [hpq_pkg::KEY_W-1:0] rd_data_b_ff;

   // write, and read both ports every cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= key_mem[rd_addr_a];
      rd_data_b_ff <= key_mem[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

FILE: rtl/max_heap_priority_queue.sv
// ----------------------------------------------------------------------------
// max_heap_priority_queue
// Binary max-heap of signed keys held in a two-read, one-write memory.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_ready/req_data) carries one command:
//   insert a key, extract the maximum, or clear. Every request produces
//   exactly one response on rsp_valid/rsp_ready/rsp_data with the removed
//   key, a status code and the entry count after the command.
//   One request is worked at a time. Sift up and sift down each handle
//   one heap level per cycle: the memory returns both children (or the
//   parent) in the cycle after the address is issued, and the compare,
//   the write back and the next read address all happen in that cycle.
//   Reset empties the heap at once (count to zero); memory is not cleared.
//   The response sits in an output register; if the receiver stalls, the
//   next request is still taken and worked, and waits for that register.
// ----------------------------------------------------------------------------
module max_heap_priority_queue #(
   parameter int CAPACITY = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  hpq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output hpq_pkg::rsp_type rsp_data
);

   localparam int AddrW  = $clog2(CAPACITY);
   localparam int CntW   = $clog2(CAPACITY + 1);
   localparam int PosW   = CntW + 1;
   localparam int KeyW   = hpq_pkg::KEY_W;
   localparam int OutCnW = hpq_pkg::CNT_W;

   hpq_pkg::state_type state_ff, state_in;
   logic [CntW-1:0]           cnt_ff, cnt_in;
   logic [PosW-1:0]           pos_ff, pos_in;
   logic [PosW-1:0]           kid_ff, kid_in;
   logic signed [KeyW-1:0]    key_ff, key_in;
   logic signed [KeyW-1:0]    res_key_ff, res_key_in;
   logic [hpq_pkg::STAT_W-1:0] res_status_ff, res_status_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   hpq_pkg::rsp_type          rsp_data_ff, rsp_data_in;

   logic                      wr_en;
   logic [AddrW-1:0]          wr_addr;
   logic signed [KeyW-1:0]    wr_data;
   logic [AddrW-1:0]          rd_addr_a;
   logic [AddrW-1:0]          rd_addr_b;
   logic signed [KeyW-1:0]    rd_data_a;
   logic signed [KeyW-1:0]    rd_data_b;
   logic                      rsp_load;

   // heap position (one-based) to memory address
   function automatic logic [AddrW-1:0] to_addr(input logic [PosW-1:0] p);
      to_addr = AddrW'(p - PosW'(1));
   endfunction

   hpq_key_ram #(
      .DEPTH  (CAPACITY),
      .ADDR_W (AddrW)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   assign req_ready = (state_ff == hpq_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hpq_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      kid_ff        <= kid_in;
      key_ff        <= key_in;
      res_key_ff    <= res_key_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // sequencer: sift up / sift down, one heap level per cycle
   always_comb begin
      logic [PosW-1:0]        new_pos;
      logic [PosW-1:0]        parent_pos;
      logic [PosW-1:0]        fill_pos;
      logic                   sel_right;
      logic [PosW-1:0]        child_pos;
      logic signed [KeyW-1:0] child_key;

      state_in      = state_ff;
      cnt_in        = cnt_ff;
      pos_in        = pos_ff;
      kid_in        = kid_ff;
      key_in        = key_ff;
      res_key_in    = res_key_ff;
      res_status_in = res_status_ff;
      wr_en         = 1'b0;
      wr_addr       = to_addr(pos_ff);
      wr_data       = key_ff;
      rd_addr_a     = to_addr(pos_ff);
      rd_addr_b     = to_addr(kid_ff);
      rsp_load      = 1'b0;

      new_pos    = PosW'(cnt_ff) + PosW'(1);
      parent_pos = pos_ff >> 1;
      fill_pos   = PosW'(cnt_ff);
      sel_right  = (kid_ff < fill_pos) && (rd_data_b > rd_data_a);
      child_pos  = kid_ff | PosW'(sel_right);
      child_key  = sel_right ? rd_data_b : rd_data_a;

      case (state_ff)
         hpq_pkg::ST_IDLE: begin
            if (req_valid) begin
               res_key_in    = '0;
               res_status_in = hpq_pkg::STATUS_OK;
               key_in        = req_data.new_key;
               state_in      = hpq_pkg::ST_DONE;
               case (req_data.func)
                  hpq_pkg::FUNC_INSERT: begin
                     if (cnt_ff >= CntW'(CAPACITY)) begin
                        res_status_in = hpq_pkg::STATUS_FULL;
                     end else begin
                        cnt_in = cnt_ff + CntW'(1);
                        pos_in = new_pos;
                        if (cnt_ff == '0) begin
                           // first key goes straight to the root
                           wr_en   = 1'b1;
                           wr_addr = to_addr(new_pos);
                           wr_data = req_data.new_key;
                        end else begin
                           rd_addr_a = to_addr(new_pos >> 1);
                           state_in  = hpq_pkg::ST_UP;
                        end
                     end
                  end
                  hpq_pkg::FUNC_EXTRACT: begin
                     if (cnt_ff == '0) begin
                        res_status_in = hpq_pkg::STATUS_EMPTY;
                     end else begin
                        // fetch root and last entry together
                        rd_addr_a = to_addr(PosW'(1));
                        rd_addr_b = to_addr(fill_pos);
                        state_in  = hpq_pkg::ST_EX0;
                     end
                  end
                  hpq_pkg::FUNC_CLEAR: begin
                     cnt_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         hpq_pkg::ST_UP: begin
            // rd_data_a holds the parent of pos_ff
            wr_en = 1'b1;
            if (pos_ff == PosW'(1) || !(key_ff > rd_data_a)) begin
               wr_data  = key_ff;
               state_in = hpq_pkg::ST_DONE;
            end else begin
               wr_data   = rd_data_a;
               pos_in    = parent_pos;
               rd_addr_a = to_addr(parent_pos >> 1);
            end
         end

         hpq_pkg::ST_EX0: begin
            res_key_in = rd_data_a;
            key_in     = rd_data_b;
            cnt_in     = cnt_ff - CntW'(1);
            pos_in     = PosW'(1);
            kid_in     = PosW'(2);
            if (cnt_ff >= CntW'(3)) begin
               rd_addr_a = to_addr(PosW'(2));
               rd_addr_b = to_addr(PosW'(3));
               state_in  = hpq_pkg::ST_DN;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = to_addr(PosW'(1));
               wr_data  = rd_data_b;
               state_in = hpq_pkg::ST_DONE;
            end
         end

         hpq_pkg::ST_DN: begin
            // rd_data_a/b hold the children at kid_ff and kid_ff+1
            wr_en = 1'b1;
            if (kid_ff > fill_pos || !(child_key > key_ff)) begin
               wr_data  = key_ff;
               state_in = hpq_pkg::ST_DONE;
            end else begin
               wr_data   = child_key;
               pos_in    = child_pos;
               kid_in    = child_pos << 1;
               rd_addr_a = to_addr(child_pos << 1);
               rd_addr_b = to_addr((child_pos << 1) | PosW'(1));
            end
         end

         hpq_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = hpq_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = hpq_pkg::ST_IDLE;
         end
      endcase
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.max_key     = res_key_ff;
         rsp_data_in.status      = res_status_ff;
         rsp_data_in.entry_count = OutCnW'(cnt_ff);
      end
   end

endmodule

FILE: rtl/hpq_checker.sv
// ----------------------------------------------------------------------------
// hpq_checker
// Port-level checks on the heap priority queue responses.
// ----------------------------------------------------------------------------
module hpq_checker #(
   parameter int CAPACITY = 256
) (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input hpq_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input hpq_pkg::rsp_type rsp_data
);

   localparam logic [hpq_pkg::CNT_W-1:0] CapCnt = hpq_pkg::CNT_W'(CAPACITY);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // only defined status codes
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == hpq_pkg::STATUS_OK ||
                     rsp_data.status == hpq_pkg::STATUS_EMPTY ||
                     rsp_data.status == hpq_pkg::STATUS_FULL))
      else $error("undefined status code");

   // failed commands return no key
   a_err_key: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != hpq_pkg::STATUS_OK |-> rsp_data.max_key == '0)
      else $error("key returned with error status");

   // empty error only when nothing is held
   a_empty_cnt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == hpq_pkg::STATUS_EMPTY
         |-> rsp_data.entry_count == '0)
      else $error("empty status with entries held");

   // full error only at capacity
   a_full_cnt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == hpq_pkg::STATUS_FULL
         |-> rsp_data.entry_count == CapCnt)
      else $error("full status below capacity");

   logic unused_req;
   assign unused_req = req_valid ^ req_ready ^ (^req_data);

endmodule

bind max_heap_priority_queue hpq_checker #(.CAPACITY(CAPACITY)) u_hpq_checker (.*);

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the max-heap priority queue against a behavioral heap kept in the
// bench. Commands go in through a clocked driver fed from a queue, and every
// response is compared field by field with the predicted response.
// ----------------------------------------------------------------------------
module testbench;

   localparam int CAPACITY    = 256;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_WAIT  = 20;

   localparam logic [hpq_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam logic signed [hpq_pkg::KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [hpq_pkg::KEY_W-1:0] KEY_MIN = 32'sh8000_0000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   hpq_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   hpq_pkg::rsp_type rsp_data;

   // commands waiting to be sent, and responses the heap model predicts
   hpq_pkg::req_type cmd_queue[$];
   hpq_pkg::rsp_type rsp_forecast[$];

   // behavioral heap, position 1 is the root
   logic signed [hpq_pkg::KEY_W-1:0] heap_keys [1:CAPACITY];
   int unsigned                      heap_fill = 0;

   int   error_count = 0;
   int   cycle_count = 0;
   int   send_wait = 0;
   int   recv_wait = 0;
   bit   send_burst = 0;
   bit   recv_burst = 0;

   max_heap_priority_queue #(.CAPACITY(CAPACITY)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // apply one command to the heap model and return the response it gives
   function automatic hpq_pkg::rsp_type heap_command(hpq_pkg::req_type cmd);
      hpq_pkg::rsp_type                 res;
      int unsigned                      pos;
      int unsigned                      child;
      bit                               settled;
      logic signed [hpq_pkg::KEY_W-1:0] moving;
      res = '0;
      case (cmd.func)
         hpq_pkg::FUNC_INSERT: begin
            if (heap_fill >= CAPACITY) begin
               res.status = hpq_pkg::STATUS_FULL;
            end else begin
               heap_fill++;
               pos = heap_fill;
               // sift up while strictly greater than the parent
               while (pos > 1 && cmd.new_key > heap_keys[pos / 2]) begin
                  heap_keys[pos] = heap_keys[pos / 2];
                  pos = pos / 2;
               end
               heap_keys[pos] = cmd.new_key;
            end
         end
         hpq_pkg::FUNC_EXTRACT: begin
            if (heap_fill == 0) begin
               res.status = hpq_pkg::STATUS_EMPTY;
            end else begin
               res.max_key = heap_keys[1];
               moving = heap_keys[heap_fill];
               heap_fill--;
               pos = 1;
               child = 2;
               settled = 0;
               // sift down past the larger child, left child wins ties
               while (!settled && child <= heap_fill) begin
                  if (child < heap_fill && heap_keys[child + 1] > heap_keys[child])
                     child++;
                  if (!(heap_keys[child] > moving)) begin
                     settled = 1;
                  end else begin
                     heap_keys[pos] = heap_keys[child];
                     pos = child;
                     child = child * 2;
                  end
               end
               heap_keys[pos] = moving;
            end
         end
         hpq_pkg::FUNC_CLEAR: begin
            heap_fill = 0;
         end
         default: ;
      endcase
      res.entry_count = heap_fill[hpq_pkg::CNT_W-1:0];
      return res;
   endfunction

   // keys: full range, a narrow band for duplicates, and the extremes
   function automatic logic signed [hpq_pkg::KEY_W-1:0] rand_key();
      case ($urandom_range(0, 3))
         0: return $signed($urandom_range(0, 8)) - 4;
         1: begin
            case ($urandom_range(0, 3))
               0: return KEY_MAX;
               1: return KEY_MIN;
               2: return 0;
               default: return -1;
            endcase
         end
         default: return $signed($urandom());
      endcase
   endfunction

   task automatic add_cmd(logic [hpq_pkg::FUNC_W-1:0] func,
                          logic signed [hpq_pkg::KEY_W-1:0] key);
      hpq_pkg::req_type cmd;
      cmd.func = func;
      cmd.new_key = key;
      cmd_queue.push_back(cmd);
   endtask

   task automatic wait_idle();
      do
         @(negedge clock);
      while (cmd_queue.size() != 0 || req_valid || rsp_forecast.size() != 0);
   endtask

   // request driver
   always @(posedge clock) begin : drive_proc
      int gap;
      if (reset) begin
         req_valid <= 1'b0;
         send_wait <= 0;
      end else if (req_valid && req_ready) begin
         if ($urandom_range(0, 31) == 0)
            send_burst = !send_burst;
         gap = send_burst ? 0 : $urandom_range(0, 6);
         if (gap == 0 && cmd_queue.size() != 0) begin
            req_data <= cmd_queue.pop_front();
         end else begin
            req_valid <= 1'b0;
            send_wait <= gap;
         end
      end else if (!req_valid) begin
         if (send_wait > 0) begin
            send_wait <= send_wait - 1;
         end else if (cmd_queue.size() != 0) begin
            req_valid <= 1'b1;
            req_data  <= cmd_queue.pop_front();
         end
      end
   end

   // response monitor: checks responses first, then predicts the newly
   // accepted request, so a response can never match its own request edge
   always @(posedge clock) begin : check_proc
      hpq_pkg::rsp_type want;
      int               stall;
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_wait <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (rsp_forecast.size() == 0) begin
               error_count++;
               $display("%0t: unexpected response %p", $time, rsp_data);
            end else begin
               want = rsp_forecast.pop_front();
               if (rsp_data.max_key !== want.max_key) begin
                  error_count++;
                  $display("%0t: max_key expected %0d actual %0d",
                           $time, want.max_key, rsp_data.max_key);
               end
               if (rsp_data.status !== want.status) begin
                  error_count++;
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, rsp_data.status);
               end
               if (rsp_data.entry_count !== want.entry_count) begin
                  error_count++;
                  $display("%0t: entry_count expected %0d actual %0d",
                           $time, want.entry_count, rsp_data.entry_count);
               end
            end
            if ($urandom_range(0, 31) == 0)
               recv_burst = !recv_burst;
            stall = recv_burst ? 0 : $urandom_range(0, 6);
            if (stall != 0) begin
               rsp_ready <= 1'b0;
               recv_wait <= stall - 1;
            end
         end else if (!rsp_ready) begin
            if (recv_wait > 0)
               recv_wait <= recv_wait - 1;
            else
               rsp_ready <= 1'b1;
         end
         if (req_valid && req_ready)
            rsp_forecast.push_back(heap_command(req_data));
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // stimulus
   initial begin : stim_proc
      int pick;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: extremes, duplicates, every operation, empty and no-op cases
      add_cmd(hpq_pkg::FUNC_EXTRACT, KEY_MAX);
      add_cmd(hpq_pkg::FUNC_INSERT, 0);
      add_cmd(hpq_pkg::FUNC_INSERT, KEY_MAX);
      add_cmd(hpq_pkg::FUNC_INSERT, KEY_MIN);
      add_cmd(hpq_pkg::FUNC_INSERT, -1);
      add_cmd(hpq_pkg::FUNC_INSERT, 1);
      add_cmd(hpq_pkg::FUNC_INSERT, 5);
      add_cmd(hpq_pkg::FUNC_INSERT, 5);
      add_cmd(FUNC_UNUSED, KEY_MIN);
      add_cmd(FUNC_UNUSED, KEY_MAX);
      repeat (8) add_cmd(hpq_pkg::FUNC_EXTRACT, 0);
      add_cmd(hpq_pkg::FUNC_INSERT, 7);
      add_cmd(hpq_pkg::FUNC_INSERT, -7);
      add_cmd(hpq_pkg::FUNC_CLEAR, -1);
      add_cmd(hpq_pkg::FUNC_EXTRACT, -1);
      add_cmd(hpq_pkg::FUNC_INSERT, KEY_MIN);
      add_cmd(hpq_pkg::FUNC_EXTRACT, 0);

      // hold the sender until everything has come back
      wait_idle();

      // mixed traffic, inserts favored so the heap grows a few levels
      repeat (120) begin
         pick = $urandom_range(0, 99);
         if (pick < 58)
            add_cmd(hpq_pkg::FUNC_INSERT, rand_key());
         else if (pick < 93)
            add_cmd(hpq_pkg::FUNC_EXTRACT, $signed($urandom()));
         else if (pick < 96)
            add_cmd(hpq_pkg::FUNC_CLEAR, $signed($urandom()));
         else
            add_cmd(FUNC_UNUSED, $signed($urandom()));
      end

      // fill to capacity, overflow, then drain with mostly extracts
      add_cmd(hpq_pkg::FUNC_CLEAR, 0);
      repeat (CAPACITY + 3) add_cmd(hpq_pkg::FUNC_INSERT, rand_key());
      repeat (120) begin
         if ($urandom_range(0, 9) < 8)
            add_cmd(hpq_pkg::FUNC_EXTRACT, $signed($urandom()));
         else
            add_cmd(hpq_pkg::FUNC_INSERT, rand_key());
      end

      wait_idle();
      repeat (DRAIN_WAIT) @(negedge clock);
      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

FILE: sim.f
rtl/hpq_pkg.sv
rtl/hpq_key_ram.sv
rtl/max_heap_priority_queue.sv
rtl/hpq_checker.sv
test/testbench.sv
